// File: rtl/ramn_pkg.sv
// shared types, codes and defaults of the mutual exclusion node
`default_nettype none

package ramn_pkg;

    // defaults for the top level parameters
    localparam int MAX_NODES_DEF = 16;
    localparam int TIME_BITS_DEF = 16;
    localparam int Q_DEPTH_DEF   = 4;

    // fixed field widths
    localparam int ID_W    = 4;
    localparam int STAMP_W = 16;
    localparam int DMASK_W = 16;
    localparam int CFG_A_W = 4;

    // configuration register indexes
    localparam logic [CFG_A_W-1:0] CFG_NODE_ID    = 4'd0;
    localparam logic [CFG_A_W-1:0] CFG_NODE_COUNT = 4'd1;

    typedef enum logic [1:0] {
        FUNC_REQ = 2'd0,
        FUNC_REL = 2'd1,
        FUNC_MSG = 2'd2
    } t_func;

    typedef enum logic [1:0] {
        KIND_REQ  = 2'd0,
        KIND_REP  = 2'd1,
        KIND_DONE = 2'd2
    } t_kind;

    // classified operation handed from front to back
    typedef enum logic [2:0] {
        OP_LREQ  = 3'd0,
        OP_LREL  = 3'd1,
        OP_MREQ  = 3'd2,
        OP_MREP  = 3'd3,
        OP_MDONE = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ACT_REQUEST = 2'd0,
        ACT_REPLY   = 2'd1,
        ACT_GRANT   = 2'd2
    } t_action;

    typedef struct packed {
        t_op               op;
        logic [ID_W-1:0]   sid;
        logic [STAMP_W-1:0] stime;
    } t_item;

    typedef struct packed {
        t_action            action;
        logic [DMASK_W-1:0] dest_mask;
        logic [STAMP_W-1:0] stamp;
        logic               last;
    } t_res;

    // results handed from back to the output queue
    typedef struct packed {
        logic [1:0] n;
        t_res       r0;
        t_res       r1;
    } t_res_push;

endpackage

`default_nettype wire

// File: rtl/ramn_queue.sv
// small register fifo with up to two writes and one read per cycle
`default_nettype none

module ramn_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic [1:0]                 i_push_n,
    input  wire logic [WIDTH-1:0]           i_wdata0,
    input  wire logic [WIDTH-1:0]           i_wdata1,
    input  wire logic                       i_pop,
    output      logic [WIDTH-1:0]           o_rdata,
    output      logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH+1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, n_wr;
    logic [AW-1:0]    r_rd, n_rd;
    logic [CNT_W-1:0] r_count, n_count;
    logic [AW-1:0]    wr_next;

    assign wr_next = r_wr + AW'(1);

    always_comb begin
        n_wr    = r_wr + AW'(i_push_n);
        n_rd    = r_rd + AW'(i_pop);
        n_count = r_count + CNT_W'(i_push_n) - CNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_n != 2'd0) begin
            r_mem[r_wr] <= i_wdata0;
        end
        if (i_push_n == 2'd2) begin
            r_mem[wr_next] <= i_wdata1;
        end
    end

    assign o_rdata = r_mem[r_rd];
    assign o_count = r_count;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue fill beyond depth");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("queue read while empty");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push_n != 2'd0) |-> ({1'b0, r_count} + (CNT_W+1)'(i_push_n)) <= (CNT_W+1)'(DEPTH))
        else $error("queue written while full");

endmodule

`default_nettype wire

// File: rtl/ramn_front.sv
// front end: accepts items and classifies them into operations
`default_nettype none

module ramn_front (
    input  wire logic                       i_valid,
    input  wire logic                       i_full,
    input  wire logic [1:0]                 i_func,
    input  wire logic [1:0]                 i_msg_kind,
    input  wire logic [ramn_pkg::ID_W-1:0]  i_sender_id,
    input  wire logic [ramn_pkg::STAMP_W-1:0] i_sender_time,
    input  wire logic [ramn_pkg::ID_W-1:0]  i_node_id,
    input  wire logic [ramn_pkg::ID_W-1:0]  i_node_count,
    output      logic                       o_push,
    output      ramn_pkg::t_item            o_item
);

    import ramn_pkg::*;

    logic keep;
    logic bad_sender;

    // request messages from no-one, ourselves or outside the group are dropped
    assign bad_sender = (i_sender_id == '0) || (i_sender_id == i_node_id)
                        || (i_sender_id > i_node_count);

    always_comb begin
        keep         = 1'b1;
        o_item.op    = OP_LREQ;
        o_item.sid   = i_sender_id;
        o_item.stime = i_sender_time;
        unique case (t_func'(i_func))
            FUNC_REQ: o_item.op = OP_LREQ;
            FUNC_REL: o_item.op = OP_LREL;
            FUNC_MSG: begin
                unique case (t_kind'(i_msg_kind))
                    KIND_REQ: begin
                        o_item.op = OP_MREQ;
                        keep      = !bad_sender;
                    end
                    KIND_REP:  o_item.op = OP_MREP;
                    KIND_DONE: o_item.op = OP_MDONE;
                    default:   keep = 1'b0;
                endcase
            end
            default: keep = 1'b0;
        endcase
    end

    assign o_push = i_valid && !i_full && keep;

endmodule

`default_nettype wire

// File: rtl/ramn_back.sv
// back end: lamport clock, request state and result generation
`default_nettype none

module ramn_back #(
    parameter int MAX_NODES = ramn_pkg::MAX_NODES_DEF,
    parameter int TIME_BITS = ramn_pkg::TIME_BITS_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_item_valid,
    input  wire ramn_pkg::t_item           i_item,
    input  wire logic                      i_room,
    input  wire logic [ramn_pkg::ID_W-1:0] i_node_id,
    input  wire logic [ramn_pkg::ID_W-1:0] i_node_count,
    output      logic                      o_pop,
    output      ramn_pkg::t_res_push       o_push
);

    import ramn_pkg::*;

    localparam int CW     = (TIME_BITS > STAMP_W) ? TIME_BITS : STAMP_W;
    localparam int MASK_W = (MAX_NODES < DMASK_W) ? MAX_NODES : DMASK_W;

    logic [TIME_BITS-1:0] r_clk, n_clk;
    logic [TIME_BITS-1:0] r_own, n_own;
    logic                 r_req, n_req;
    logic [3:0]           r_rc, n_rc;
    logic [3:0]           r_fp, n_fp;
    logic [MASK_W-1:0]    r_dmask, n_dmask;

    logic [3:0]           need;
    logic [4:0]           sum_now;
    logic                 granted;
    logic [CW-1:0]        st_w, tmax_w, st_sat, own_w;
    logic [TIME_BITS-1:0] st_t, mx, c_msg, c_msg2, c_loc;
    logic                 defer;
    logic [3:0]           rc_inc, fp_inc;
    logic                 g_lreq, g_rep, g_done;
    logic [MASK_W-1:0]    peers, sid_bit;
    logic                 exec;

    function automatic logic [TIME_BITS-1:0] sat_inc(input logic [TIME_BITS-1:0] v);
        sat_inc = (v == '1) ? v : v + TIME_BITS'(1);
    endfunction

    function automatic logic [STAMP_W-1:0] to_stamp(input logic [TIME_BITS-1:0] v);
        logic [CW-1:0] w;
        w        = CW'(v);
        to_stamp = w[STAMP_W-1:0];
    endfunction

    always_comb begin
        need    = (i_node_count == '0) ? 4'd0 : i_node_count - 4'd1;
        sum_now = {1'b0, r_rc} + {1'b0, r_fp};
        granted = r_req && (sum_now >= {1'b0, need});

        // merge with the sender stamp, saturating it into our clock range
        st_w   = CW'(i_item.stime);
        tmax_w = CW'({TIME_BITS{1'b1}});
        st_sat = (st_w > tmax_w) ? tmax_w : st_w;
        st_t   = st_sat[TIME_BITS-1:0];
        mx     = (r_clk > st_t) ? r_clk : st_t;
        c_msg  = sat_inc(mx);
        c_msg2 = sat_inc(c_msg);
        c_loc  = sat_inc(r_clk);

        own_w = CW'(r_own);
        defer = r_req && (granted || (own_w < st_w)
                          || ((own_w == st_w) && (i_node_id < i_item.sid)));

        rc_inc = (r_rc == 4'hF) ? r_rc : r_rc + 4'd1;
        fp_inc = (r_fp == 4'hF) ? r_fp : r_fp + 4'd1;
        g_lreq = {1'b0, r_fp} >= {1'b0, need};
        g_rep  = ({1'b0, rc_inc} + {1'b0, r_fp}) >= {1'b0, need};
        g_done = r_req && (({1'b0, r_rc} + {1'b0, fp_inc}) >= {1'b0, need});

        for (int i = 0; i < MASK_W; i++) begin
            peers[i]   = (i != 0) && (4'(i) <= i_node_count) && (4'(i) != i_node_id);
            sid_bit[i] = (i_item.sid == 4'(i));
        end
    end

    assign exec  = i_item_valid && i_room;
    assign o_pop = exec;

    always_comb begin
        n_clk   = r_clk;
        n_own   = r_own;
        n_req   = r_req;
        n_rc    = r_rc;
        n_fp    = r_fp;
        n_dmask = r_dmask;
        o_push  = '0;
        if (exec) begin
            unique case (i_item.op)
                OP_LREQ: begin
                    if (!r_req) begin
                        n_clk = c_loc;
                        n_own = c_loc;
                        n_req = 1'b1;
                        n_rc  = '0;
                        o_push.r0.action    = ACT_REQUEST;
                        o_push.r0.dest_mask = DMASK_W'(peers);
                        o_push.r0.stamp     = to_stamp(c_loc);
                        o_push.r0.last      = !g_lreq;
                        o_push.r1.action    = ACT_GRANT;
                        o_push.r1.dest_mask = '0;
                        o_push.r1.stamp     = to_stamp(c_loc);
                        o_push.r1.last      = 1'b1;
                        o_push.n            = g_lreq ? 2'd2 : 2'd1;
                    end
                end
                OP_LREL: begin
                    if (granted) begin
                        n_clk   = c_loc;
                        n_req   = 1'b0;
                        n_rc    = '0;
                        n_dmask = '0;
                        o_push.r0.action    = ACT_REPLY;
                        o_push.r0.dest_mask = DMASK_W'(r_dmask);
                        o_push.r0.stamp     = to_stamp(c_loc);
                        o_push.r0.last      = 1'b1;
                        o_push.n            = 2'd1;
                    end
                end
                OP_MREQ: begin
                    if (defer) begin
                        n_clk   = c_msg;
                        n_dmask = r_dmask | sid_bit;
                    end else begin
                        n_clk = c_msg2;
                        o_push.r0.action    = ACT_REPLY;
                        o_push.r0.dest_mask = DMASK_W'(sid_bit);
                        o_push.r0.stamp     = to_stamp(c_msg2);
                        o_push.r0.last      = 1'b1;
                        o_push.n            = 2'd1;
                    end
                end
                OP_MREP: begin
                    n_clk = c_msg;
                    if (r_req && !granted) begin
                        n_rc = rc_inc;
                        if (g_rep) begin
                            o_push.r0.action    = ACT_GRANT;
                            o_push.r0.dest_mask = '0;
                            o_push.r0.stamp     = to_stamp(c_msg);
                            o_push.r0.last      = 1'b1;
                            o_push.n            = 2'd1;
                        end
                    end
                end
                OP_MDONE: begin
                    n_clk = c_msg;
                    n_fp  = fp_inc;
                    if (!granted && g_done) begin
                        o_push.r0.action    = ACT_GRANT;
                        o_push.r0.dest_mask = '0;
                        o_push.r0.stamp     = to_stamp(c_msg);
                        o_push.r0.last      = 1'b1;
                        o_push.n            = 2'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clk   <= '0;
            r_own   <= '0;
            r_req   <= 1'b0;
            r_rc    <= '0;
            r_fp    <= '0;
            r_dmask <= '0;
        end else begin
            r_clk   <= n_clk;
            r_own   <= n_own;
            r_req   <= n_req;
            r_rc    <= n_rc;
            r_fp    <= n_fp;
            r_dmask <= n_dmask;
        end
    end

    a_clock_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_clk >= $past(r_clk))
        else $error("lamport clock went backwards");

    a_grant_while_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.n != 2'd0) && (o_push.r0.action == ACT_GRANT) |=> r_req)
        else $error("grant without a pending request");

    a_release_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        exec && (i_item.op == OP_LREL) && granted |=> (r_dmask == '0) && !r_req)
        else $error("release left deferred peers or request state");

endmodule

`default_nettype wire

// File: rtl/ricart_agrawala_mutex_node_unit.sv
// top level of one ricart-agrawala mutual exclusion node with lamport clock
//
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------------------------
//  in       | i_valid / o_stall      | i_func, i_msg_kind, i_sender_id, i_sender_time
//  out      | o_valid / i_stall      | o_action, o_dest_mask, o_stamp, o_last
//  cfg      | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// one item per cycle is taken while the input queue has room; items go via the input queue
// and back end to the output queue, which gives one result per cycle while not stalled
// reset is synchronous and active low; it clears clock, request state and both queues
// o_stall rises only when the input queue is full; the back end waits while the output
// queue has fewer than two free places, so a stalled output backs up into the input
`default_nettype none

module ricart_agrawala_mutex_node_unit #(
    parameter int MAX_NODES = ramn_pkg::MAX_NODES_DEF,
    parameter int TIME_BITS = ramn_pkg::TIME_BITS_DEF,
    parameter int Q_DEPTH   = ramn_pkg::Q_DEPTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // input channel
    input  wire logic                          i_valid,
    output      logic                          o_stall,
    input  wire logic [1:0]                    i_func,
    input  wire logic [1:0]                    i_msg_kind,
    input  wire logic [ramn_pkg::ID_W-1:0]     i_sender_id,
    input  wire logic [ramn_pkg::STAMP_W-1:0]  i_sender_time,
    // output channel
    output      logic                          o_valid,
    input  wire logic                          i_stall,
    output      logic [1:0]                    o_action,
    output      logic [ramn_pkg::DMASK_W-1:0]  o_dest_mask,
    output      logic [ramn_pkg::STAMP_W-1:0]  o_stamp,
    output      logic                          o_last,
    // configuration channel
    input  wire logic                          i_cfg_valid,
    output      logic                          o_cfg_ready,
    input  wire logic [ramn_pkg::CFG_A_W-1:0]  i_cfg_index,
    input  wire logic [ramn_pkg::ID_W-1:0]     i_cfg_data
);

    import ramn_pkg::*;

    localparam int CNT_W  = $clog2(Q_DEPTH+1);
    localparam int ITEM_W = $bits(t_item);
    localparam int RES_W  = $bits(t_res);

    // configuration registers
    logic [ID_W-1:0] r_node_id;
    logic [ID_W-1:0] r_node_count;

    // front to queue
    logic             f_push;
    t_item            f_item;
    logic [CNT_W-1:0] iq_count;
    logic [ITEM_W-1:0] iq_rdata;

    // back end
    logic             b_pop;
    t_res_push        b_push;
    logic             out_room;

    // output queue
    logic [CNT_W-1:0] oq_count;
    logic [RES_W-1:0] oq_rdata;
    t_res             oq_head;
    logic             out_take;

    // configuration is always taken
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_id    <= 4'd1;
            r_node_count <= 4'd2;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_NODE_ID:    r_node_id    <= i_cfg_data;
                CFG_NODE_COUNT: r_node_count <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input side stalls only on a full queue
    assign o_stall = (iq_count == CNT_W'(Q_DEPTH));

    ramn_front u_front (
        .i_valid       (i_valid),
        .i_full        (o_stall),
        .i_func        (i_func),
        .i_msg_kind    (i_msg_kind),
        .i_sender_id   (i_sender_id),
        .i_sender_time (i_sender_time),
        .i_node_id     (r_node_id),
        .i_node_count  (r_node_count),
        .o_push        (f_push),
        .o_item        (f_item)
    );

    // classified items waiting for the back end
    ramn_queue #(
        .WIDTH (ITEM_W),
        .DEPTH (Q_DEPTH)
    ) u_in_q (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n ({1'b0, f_push}),
        .i_wdata0 (f_item),
        .i_wdata1 ('0),
        .i_pop    (b_pop),
        .o_rdata  (iq_rdata),
        .o_count  (iq_count)
    );

    // an item may make two results, so the back end needs two free places
    assign out_room = (oq_count <= CNT_W'(Q_DEPTH - 2));

    ramn_back #(
        .MAX_NODES (MAX_NODES),
        .TIME_BITS (TIME_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (iq_count != '0),
        .i_item       (t_item'(iq_rdata)),
        .i_room       (out_room),
        .i_node_id    (r_node_id),
        .i_node_count (r_node_count),
        .o_pop        (b_pop),
        .o_push       (b_push)
    );

    assign out_take = o_valid && !i_stall;

    // result skid queue, keeps the head steady while the output stalls
    ramn_queue #(
        .WIDTH (RES_W),
        .DEPTH (Q_DEPTH)
    ) u_out_q (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n (b_push.n),
        .i_wdata0 (b_push.r0),
        .i_wdata1 (b_push.r1),
        .i_pop    (out_take),
        .o_rdata  (oq_rdata),
        .o_count  (oq_count)
    );

    assign oq_head     = t_res'(oq_rdata);
    assign o_valid     = (oq_count != '0);
    assign o_action    = oq_head.action;
    assign o_dest_mask = oq_head.dest_mask;
    assign o_stamp     = oq_head.stamp;
    assign o_last      = oq_head.last;

endmodule

`default_nettype wire

// File: bench/ricart_agrawala_mutex_node_unit_tb.sv
// self-checking bench for one ricart-agrawala mutual exclusion node, directed and random items
`timescale 1ns / 100ps

module ricart_agrawala_mutex_node_unit_tb;

    import ramn_pkg::*;

    // block inputs, all known from time zero
    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_valid       = 1'b0;
    logic [1:0]           i_func        = '0;
    logic [1:0]           i_msg_kind    = '0;
    logic [ID_W-1:0]      i_sender_id   = '0;
    logic [STAMP_W-1:0]   i_sender_time = '0;
    logic                 i_stall       = 1'b0;
    logic                 i_cfg_valid   = 1'b0;
    logic [CFG_A_W-1:0]   i_cfg_index   = '0;
    logic [ID_W-1:0]      i_cfg_data    = '0;

    // block outputs
    logic                 o_stall;
    logic                 o_valid;
    logic [1:0]           o_action;
    logic [DMASK_W-1:0]   o_dest_mask;
    logic [STAMP_W-1:0]   o_stamp;
    logic                 o_last;
    logic                 o_cfg_ready;

    // our own copy of the node: configuration
    logic [3:0]           cfg_id    = 4'd1;
    logic [3:0]           cfg_count = 4'd2;

    // our own copy of the node: protocol state
    logic [15:0]          node_clock  = '0;
    logic [15:0]          own_stamp   = '0;
    logic                 asking      = 1'b0;
    logic [3:0]           reply_tally = '0;
    logic [3:0]           done_tally  = '0;
    logic [15:0]          held_mask   = '0;

    // results owed by the node, oldest first
    t_res                 due_results[$];
    int                   faults    = 0;

    // idling, in percent per cycle
    int                   gap_pct   = 0;
    int                   stall_pct = 0;

    ricart_agrawala_mutex_node_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_func        (i_func),
        .i_msg_kind    (i_msg_kind),
        .i_sender_id   (i_sender_id),
        .i_sender_time (i_sender_time),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_action      (o_action),
        .o_dest_mask   (o_dest_mask),
        .o_stamp       (o_stamp),
        .o_last        (o_last),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------------
    // prediction
    // ---------------------------------------------------------------------

    // lamport clock step, held at the top value
    function automatic logic [15:0] tick(logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    // four-bit tally, held at fifteen
    function automatic logic [3:0] bump(logic [3:0] v);
        return (v == 4'hF) ? v : v + 4'd1;
    endfunction

    // entry is held once replies plus finished peers cover everyone else
    function automatic logic node_granted();
        int need;
        need = (cfg_count == 0) ? 0 : int'(cfg_count) - 1;
        return asking && (int'(reply_tally) + int'(done_tally) >= need);
    endfunction

    // every participant except this node
    function automatic logic [15:0] peer_set();
        logic [15:0] m;
        m = '0;
        for (int i = 1; i < 16; i++)
            if (i <= cfg_count && i != cfg_id)
                m[i] = 1'b1;
        return m;
    endfunction

    function automatic void owe(t_action a, logic [15:0] m, logic [15:0] s, logic l);
        t_res r;
        r.action    = a;
        r.dest_mask = m;
        r.stamp     = s;
        r.last      = l;
        due_results.push_back(r);
    endfunction

    // apply one accepted item to our copy and queue what the node must send
    function automatic void advance_node(logic [1:0] f, logic [1:0] k, logic [3:0] sid,
                                         logic [15:0] stime);
        logic        was;
        logic        hold;
        logic [15:0] peak;
        case (f)
            FUNC_REQ: begin
                // a second request while one is open is dropped
                if (asking)
                    return;
                node_clock  = tick(node_clock);
                own_stamp   = node_clock;
                asking      = 1'b1;
                reply_tally = '0;
                // nobody to wait for: request and grant in one go
                if (node_granted()) begin
                    owe(ACT_REQUEST, peer_set(), node_clock, 1'b0);
                    owe(ACT_GRANT, '0, node_clock, 1'b1);
                end else begin
                    owe(ACT_REQUEST, peer_set(), node_clock, 1'b1);
                end
            end
            FUNC_REL: begin
                if (!node_granted())
                    return;
                node_clock = tick(node_clock);
                owe(ACT_REPLY, held_mask, node_clock, 1'b1);
                held_mask   = '0;
                asking      = 1'b0;
                reply_tally = '0;
            end
            FUNC_MSG: begin
                if (k != KIND_REQ && k != KIND_REP && k != KIND_DONE)
                    return;
                // requests from no-one, ourselves or outside the group are dropped
                if (k == KIND_REQ && (sid == 0 || sid == cfg_id || sid > cfg_count))
                    return;
                peak       = (stime > node_clock) ? stime : node_clock;
                node_clock = tick(peak);
                if (k == KIND_REQ) begin
                    // defer when inside, or our claim is older, or equal and our id lower
                    hold = asking && (node_granted() || own_stamp < stime ||
                                      (own_stamp == stime && cfg_id < sid));
                    if (hold) begin
                        held_mask = held_mask | (16'd1 << sid);
                    end else begin
                        node_clock = tick(node_clock);
                        owe(ACT_REPLY, 16'd1 << sid, node_clock, 1'b1);
                    end
                end else begin
                    was = node_granted();
                    if (k == KIND_REP) begin
                        // stray replies only move the clock
                        if (!asking || was)
                            return;
                        reply_tally = bump(reply_tally);
                    end else begin
                        done_tally = bump(done_tally);
                    end
                    if (!was && node_granted())
                        owe(ACT_GRANT, '0, node_clock, 1'b1);
                end
            end
            default: ;
        endcase
    endfunction

    // ---------------------------------------------------------------------
    // result side: random stall and in-order compare
    // ---------------------------------------------------------------------

    always @(posedge i_clk) begin
        i_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin : result_check
        t_res want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (due_results.size() == 0) begin
                faults++;
                if (faults <= 10)
                    $display("unexpected result item: action %0d mask %h stamp %h last %0d",
                             o_action, o_dest_mask, o_stamp, o_last);
            end else begin
                want = due_results.pop_front();
                if (o_action !== want.action || o_dest_mask !== want.dest_mask ||
                    o_stamp !== want.stamp || o_last !== want.last) begin
                    faults++;
                    if (faults <= 10)
                        $display(
                            "exp/act action %0d/%0d mask %h/%h stamp %h/%h last %0d/%0d",
                            want.action, o_action, want.dest_mask, o_dest_mask,
                            want.stamp, o_stamp, want.last, o_last);
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // item side
    // ---------------------------------------------------------------------

    // offer one item, keep it steady until taken, then predict from it
    task automatic send_item(logic [1:0] f, logic [1:0] k, logic [3:0] sid, logic [15:0] stime);
        while (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_func        <= f;
        i_msg_kind    <= k;
        i_sender_id   <= sid;
        i_sender_time <= stime;
        do @(posedge i_clk); while (o_stall);
        advance_node(f, k, sid, stime);
    endtask

    // hold off until every owed result is in and the back end has gone quiet
    task automatic drain_node(int settle);
        i_valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    // write both registers back to back, valid kept high between them
    task automatic set_config(logic [3:0] id, logic [3:0] count);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_NODE_ID;
        i_cfg_data  <= id;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_id = id;
        i_cfg_index <= CFG_NODE_COUNT;
        i_cfg_data  <= count;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_count = count;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_idling(int mode);
        case (mode)
            0:       begin gap_pct = 0;  stall_pct = 0;  end
            1:       begin gap_pct = 72; stall_pct = 0;  end
            2:       begin gap_pct = 0;  stall_pct = 72; end
            default: begin gap_pct = 11; stall_pct = 11; end
        endcase
    endtask

    // stamp a few steps either side of a base, clipped to the field
    function automatic logic [15:0] stamp_near(logic [15:0] base, int spread);
        int v;
        v = int'(base) + int'($urandom_range(2 * spread)) - spread;
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return v[15:0];
    endfunction

    // a legal peer id, or anything when this node has no peers
    function automatic logic [3:0] pick_peer();
        logic [3:0] s;
        if (cfg_count == 0 || (cfg_count == 1 && cfg_id == 1))
            return 4'($urandom_range(15));
        do s = 4'($urandom_range(cfg_count, 1)); while (s == cfg_id);
        return s;
    endfunction

    // mostly well-formed rounds: request, replies and rival requests, grant, release
    task automatic run_traffic(int count, int done_pct, int wide_pct, logic done_capped);
        int          r;
        logic [1:0]  f;
        logic [1:0]  k;
        logic [3:0]  s;
        logic [15:0] t;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(99);
            f = FUNC_MSG;
            k = KIND_REQ;
            s = pick_peer();
            t = stamp_near(node_clock, 6);
            if ($urandom_range(99) < done_pct && (!done_capped || done_tally < 2)) begin
                k = KIND_DONE;
            end else if (!asking) begin
                if (r < 45)
                    f = FUNC_REQ;
                else if (r < 80)
                    k = KIND_REQ;
                else if (r < 88)
                    k = KIND_REP;
                else if (r < 93)
                    f = FUNC_REL;
                else
                    r = -1;
            end else if (!node_granted()) begin
                if (r < 50) begin
                    k = KIND_REP;
                end else if (r < 80) begin
                    t = stamp_near(own_stamp, 2);
                end else if (r < 85) begin
                    f = FUNC_REQ;
                end else if (r < 90) begin
                    f = FUNC_REL;
                end else begin
                    r = -1;
                end
            end else begin
                if (r < 40) begin
                    f = FUNC_REL;
                end else if (r < 70) begin
                    t = stamp_near(own_stamp, 2);
                end else if (r < 80) begin
                    k = KIND_REP;
                end else if (r < 85) begin
                    f = FUNC_REQ;
                end else begin
                    r = -1;
                end
            end
            // noise: unknown codes, bad ids, stamps far off
            if (r < 0) begin
                f = 2'($urandom_range(3));
                k = 2'($urandom_range(3));
                s = 4'($urandom_range(15));
                t = stamp_near(node_clock, 40);
            end
            // local items carry junk in the message fields
            if (f != FUNC_MSG) begin
                k = 2'($urandom_range(3));
                s = 4'($urandom_range(15));
                t = 16'($urandom_range(65535));
            end
            if ($urandom_range(99) < wide_pct)
                t = 16'($urandom_range(65535));
            send_item(f, k, s, t);
        end
    endtask

    // ---------------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------------

    // one full round as node 2 of 3, with ties broken both ways
    task automatic test_directed_round();
        set_config(4'd2, 4'd3);
        send_item(FUNC_MSG, KIND_REQ, 4'd1, 16'd5);          // idle, answered at once
        send_item(FUNC_REQ, KIND_REQ, 4'd0, 16'd0);          // request to nodes 1 and 3
        send_item(FUNC_REQ, KIND_REQ, 4'd0, 16'd0);          // already asking, dropped
        send_item(FUNC_REL, KIND_REQ, 4'd0, 16'd0);          // not inside, dropped
        send_item(FUNC_MSG, KIND_REQ, 4'd3, own_stamp);      // tie, our id lower: deferred
        send_item(FUNC_MSG, KIND_REQ, 4'd1, own_stamp);      // tie, their id lower: answered
        send_item(FUNC_MSG, KIND_REQ, 4'd1, own_stamp + 16'd1); // younger claim: deferred
        send_item(FUNC_MSG, KIND_REP, 4'd1, 16'd0);
        send_item(FUNC_MSG, KIND_REP, 4'd3, 16'd0);          // completes the count: grant
        send_item(FUNC_MSG, KIND_REP, 4'd3, 16'd0);          // already inside, clock only
        send_item(FUNC_MSG, KIND_REQ, 4'd3, 16'd0);          // inside, so deferred anyway
        send_item(FUNC_REL, KIND_REQ, 4'd0, 16'd0);          // replies to every deferred node
        send_item(FUNC_MSG, KIND_REP, 4'd1, 16'hFFF0 >> 4);  // reply while idle
    endtask

    // items the node must drop without moving the clock
    task automatic test_rejected_items();
        send_item(FUNC_MSG, KIND_REQ, 4'd0, 16'd9);          // sender id zero
        send_item(FUNC_MSG, KIND_REQ, 4'd2, 16'd9);          // our own id
        send_item(FUNC_MSG, KIND_REQ, 4'd4, 16'd9);          // outside the group
        send_item(2'd3, KIND_REQ, 4'd1, 16'd9);              // unknown function
        send_item(FUNC_MSG, 2'd3, 4'd1, 16'd9);              // unknown message kind
    endtask

    // a group of one: the request is granted in the same item
    task automatic test_lone_node();
        drain_node(16);
        set_config(4'd1, 4'd1);
        send_item(FUNC_REQ, KIND_REQ, 4'd0, 16'd0);
        send_item(FUNC_REL, KIND_REQ, 4'd0, 16'd0);
    endtask

    // random rounds under one setting, running through every idling mode
    task automatic test_random_traffic(logic [3:0] id, logic [3:0] count, int items);
        drain_node(16);
        set_config(id, count);
        for (int m = 0; m < 4; m++) begin
            set_idling(m);
            run_traffic(items / 4, 1, 0, 1'b1);
        end
    endtask

    // late phase: finished-peer notices freely and full-range stamps drive
    // both the tally and the clock into saturation
    task automatic test_saturation();
        drain_node(16);
        set_config(4'd1, 4'd15);
        for (int m = 0; m < 4; m++) begin
            set_idling(m);
            run_traffic(40, 15, 30, 1'b0);
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_round();
        test_rejected_items();
        test_lone_node();
        test_random_traffic(4'd1, 4'd2, 300);
        test_random_traffic(4'd15, 4'd15, 300);
        test_random_traffic(4'd8, 4'd15, 300);
        test_random_traffic(4'd3, 4'd5, 300);
        test_random_traffic(4'd15, 4'd1, 152);
        test_random_traffic(4'($urandom_range(15, 1)), 4'($urandom_range(15, 1)), 300);
        test_saturation();
        set_idling(0);
        drain_node(16);
        if (faults == 0 && due_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
